@@ sv/imh_pkg.sv @@
`timescale 1ns / 1ps
package imh_pkg;

	localparam int CAPACITY = 512;
	localparam int ID_COUNT = 512;
	localparam int ID_W     = $clog2(ID_COUNT);
	localparam int VAL_W    = 32;
	localparam int POS_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int COUNT_W  = 10;
	localparam int KIND_W   = 2;
	localparam int STAT_W   = 2;
	localparam int CLR_W    = $clog2(ID_COUNT + 1);

	localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic signed [VAL_W-1:0] val;
	} slot_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		slot_t             wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} slot_req_t;

	typedef struct packed {
		logic             we;
		logic [ID_W-1:0]  waddr;
		logic [POS_W-1:0] wdata;
		logic             re;
		logic [ID_W-1:0]  raddr;
	} map_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic                    is_empty;
		logic [COUNT_W-1:0]      entry_count;
		logic signed [VAL_W-1:0] min_value;
		logic [ID_W-1:0]         min_index;
	} res_t;

	// Heap positions run from 1; the slot memory is addressed from 0.
	function automatic logic [ADDR_W-1:0] pos2addr(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] a;
		a = pos - POS_W'(1);
		return a[ADDR_W-1:0];
	endfunction

endpackage

@@ sv/imh_ram.sv @@
`timescale 1ns / 1ps
module imh_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/imh_ctrl.sv @@
`timescale 1ns / 1ps
module imh_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [imh_pkg::KIND_W-1:0]   in_kind,
	input  logic [imh_pkg::ID_W-1:0]     in_id,
	input  logic [imh_pkg::VAL_W-1:0]    in_val,
	output imh_pkg::slot_req_t           slot_req,
	input  imh_pkg::slot_t               slot_rdata,
	output imh_pkg::map_req_t            map_req,
	input  logic [imh_pkg::POS_W-1:0]    map_rdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output imh_pkg::res_t                out_res
);
	import imh_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLR   = 4'd1;
	localparam logic [3:0] ST_PMAP  = 4'd2;
	localparam logic [3:0] ST_PSLOT = 4'd3;
	localparam logic [3:0] ST_UP    = 4'd4;
	localparam logic [3:0] ST_UPCMP = 4'd5;
	localparam logic [3:0] ST_HOLE  = 4'd6;
	localparam logic [3:0] ST_POPA  = 4'd7;
	localparam logic [3:0] ST_POPB  = 4'd8;
	localparam logic [3:0] ST_DOWN  = 4'd9;
	localparam logic [3:0] ST_DL    = 4'd10;
	localparam logic [3:0] ST_DR    = 4'd11;
	localparam logic [3:0] ST_DCMP  = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;
	localparam logic [3:0] ST_FIN2  = 4'd14;

	logic [3:0]         state_q;
	logic [ID_W-1:0]    id_q;
	logic [VAL_W-1:0]   val_q;
	logic [POS_W-1:0]   occ_q;
	logic [POS_W-1:0]   cur_q;
	slot_t              cur_e_q;
	slot_t              ch_q;
	logic [POS_W-1:0]   chpos_q;
	logic [STAT_W-1:0]  status_q;
	logic [CLR_W-1:0]   clr_q;
	logic               clr_resp_q;
	logic               out_valid_q;
	res_t               res_q;

	logic               present;
	logic [POS_W:0]     child;
	logic               child_in;
	logic               up_less;
	logic               down_less;
	logic               load_out;

	assign present   = (map_rdata != '0) && (map_rdata <= occ_q);
	assign child     = {cur_q, 1'b0};
	assign child_in  = child <= {1'b0, occ_q};
	assign up_less   = $signed(cur_e_q.val) < $signed(slot_rdata.val);
	assign down_less = $signed(ch_q.val) < $signed(cur_e_q.val);
	assign load_out  = (state_q == ST_FIN2) && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_comb begin
		slot_req = '0;
		map_req  = '0;
		case (state_q)
			ST_IDLE: begin
				map_req.re    = in_valid && (in_kind == KIND_PUSH);
				map_req.raddr = in_id;
				slot_req.re   = in_valid && (in_kind == KIND_POP);
				slot_req.raddr = '0;
			end
			ST_CLR: begin
				map_req.we    = 1'b1;
				map_req.waddr = clr_q[ID_W-1:0];
			end
			ST_PMAP: begin
				slot_req.re    = present;
				slot_req.raddr = pos2addr(map_rdata);
			end
			ST_UP: begin
				slot_req.re    = (cur_q != POS_W'(1));
				slot_req.raddr = pos2addr(cur_q >> 1);
			end
			ST_UPCMP: begin
				slot_req.we    = up_less;
				slot_req.waddr = pos2addr(cur_q);
				slot_req.wdata = slot_rdata;
				map_req.we     = up_less;
				map_req.waddr  = slot_rdata.id;
				map_req.wdata  = cur_q;
			end
			ST_HOLE: begin
				slot_req.we    = 1'b1;
				slot_req.waddr = pos2addr(cur_q);
				slot_req.wdata = cur_e_q;
				map_req.we     = 1'b1;
				map_req.waddr  = cur_e_q.id;
				map_req.wdata  = cur_q;
			end
			ST_POPA: begin
				// The old root leaves the heap.
				map_req.we     = 1'b1;
				map_req.waddr  = slot_rdata.id;
				slot_req.re    = 1'b1;
				slot_req.raddr = pos2addr(occ_q);
			end
			ST_DOWN: begin
				slot_req.re    = child_in;
				slot_req.raddr = pos2addr(child[POS_W-1:0]);
			end
			ST_DL: begin
				slot_req.re    = chpos_q < occ_q;
				slot_req.raddr = pos2addr(chpos_q + POS_W'(1));
			end
			ST_DCMP: begin
				slot_req.we    = down_less;
				slot_req.waddr = pos2addr(cur_q);
				slot_req.wdata = ch_q;
				map_req.we     = down_less;
				map_req.waddr  = ch_q.id;
				map_req.wdata  = cur_q;
			end
			ST_FIN: begin
				slot_req.re    = 1'b1;
				slot_req.raddr = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			occ_q       <= '0;
			clr_q       <= '0;
			clr_resp_q  <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						id_q     <= in_id;
						val_q    <= in_val;
						status_q <= ((in_kind == KIND_POP) && (occ_q == '0)) ?
							STAT_EMPTY : STAT_OK;
						case (in_kind)
							KIND_PUSH: state_q <= ST_PMAP;
							KIND_POP: begin
								state_q <= (occ_q == '0) ? ST_FIN : ST_POPA;
							end
							KIND_CLEAR: begin
								occ_q      <= '0;
								clr_q      <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= ST_CLR;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(ID_COUNT - 1)) begin
						state_q <= clr_resp_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_PMAP: begin
					if (present) begin
						cur_q   <= map_rdata;
						state_q <= ST_PSLOT;
					end else if (occ_q == POS_W'(CAPACITY)) begin
						status_q <= STAT_FULL;
						state_q  <= ST_FIN;
					end else begin
						occ_q       <= occ_q + POS_W'(1);
						cur_q       <= occ_q + POS_W'(1);
						cur_e_q.id  <= id_q;
						cur_e_q.val <= val_q;
						state_q     <= ST_UP;
					end
				end
				ST_PSLOT: begin
					if ($signed(val_q) < $signed(slot_rdata.val)) begin
						cur_e_q.id  <= slot_rdata.id;
						cur_e_q.val <= val_q;
						state_q     <= ST_UP;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_UP: begin
					state_q <= (cur_q == POS_W'(1)) ? ST_HOLE : ST_UPCMP;
				end
				ST_UPCMP: begin
					if (up_less) begin
						cur_q   <= cur_q >> 1;
						state_q <= ST_UP;
					end else begin
						state_q <= ST_HOLE;
					end
				end
				ST_HOLE: state_q <= ST_FIN;
				ST_POPA: state_q <= ST_POPB;
				ST_POPB: begin
					occ_q <= occ_q - POS_W'(1);
					if (occ_q == POS_W'(1)) begin
						state_q <= ST_FIN;
					end else begin
						cur_q   <= POS_W'(1);
						cur_e_q <= slot_rdata;
						state_q <= ST_DOWN;
					end
				end
				ST_DOWN: begin
					if (child_in) begin
						chpos_q <= child[POS_W-1:0];
						state_q <= ST_DL;
					end else begin
						state_q <= ST_HOLE;
					end
				end
				ST_DL: begin
					ch_q    <= slot_rdata;
					state_q <= (chpos_q < occ_q) ? ST_DR : ST_DCMP;
				end
				ST_DR: begin
					// On a tie the left child is kept.
					if ($signed(slot_rdata.val) < $signed(ch_q.val)) begin
						ch_q    <= slot_rdata;
						chpos_q <= chpos_q + POS_W'(1);
					end
					state_q <= ST_DCMP;
				end
				ST_DCMP: begin
					if (down_less) begin
						cur_q   <= chpos_q;
						state_q <= ST_DOWN;
					end else begin
						state_q <= ST_HOLE;
					end
				end
				ST_FIN: state_q <= ST_FIN2;
				ST_FIN2: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						clr_resp_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.status      <= status_q;
			res_q.is_empty    <= (occ_q == '0);
			res_q.entry_count <= COUNT_W'(occ_q);
			res_q.min_index   <= (occ_q == '0) ? '0 : slot_rdata.id;
			res_q.min_value   <= (occ_q == '0) ? '0 : slot_rdata.val;
		end
	end
endmodule

@@ sv/indexed_min_heap.sv @@
`timescale 1ns / 1ps
// Indexed binary min-heap with a position map. Each input beat is a push (insert, or lower
// the value of an identifier already held), a pop of the minimum or a clear, and gives one
// output beat with the root, the count, an empty flag and a status. Slots and map sit in two
// single-port-read memories with registered reads. A sift passes at most log2(512) = 9
// parent-child steps, going up for a push and down for a pop. After reset, and for every clear,
// the position map is swept once over all 512 entries, one entry a cycle, before the next input
// beat is taken. A new input beat is taken while the previous result still waits.
module indexed_min_heap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // entry_index[8:0], entry_value[40:9], zeros
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // min_index[8:0], min_value[40:9], entry_count[50:41], zeros
	output logic [2:0]  m_tuser   // is_empty[0], status[2:1]
);
	import imh_pkg::*;

	slot_req_t          slot_req;
	map_req_t           map_req;
	slot_t              slot_rdata;
	logic [POS_W-1:0]   map_rdata;
	res_t               res;
	logic [$bits(slot_t)-1:0] slot_rbits;

	assign slot_rdata = slot_t'(slot_rbits);

	imh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_id      (s_tdata[ID_W-1:0]),
		.in_val     (s_tdata[ID_W+VAL_W-1:ID_W]),
		.slot_req   (slot_req),
		.slot_rdata (slot_rdata),
		.map_req    (map_req),
		.map_rdata  (map_rdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	imh_ram #(.DEPTH(CAPACITY), .WIDTH($bits(slot_t))) u_slots (
		.clk   (clk),
		.we    (slot_req.we),
		.waddr (slot_req.waddr),
		.wdata (slot_req.wdata),
		.re    (slot_req.re),
		.raddr (slot_req.raddr),
		.rdata (slot_rbits)
	);

	imh_ram #(.DEPTH(ID_COUNT), .WIDTH(POS_W)) u_map (
		.clk   (clk),
		.we    (map_req.we),
		.waddr (map_req.waddr),
		.wdata (map_req.wdata),
		.re    (map_req.re),
		.raddr (map_req.raddr),
		.rdata (map_rdata)
	);

	assign m_tdata = {5'd0, res.entry_count, res.min_value, res.min_index};
	assign m_tuser = {res.status, res.is_empty};
endmodule
